### hw/rtl/isolated_peak_clip_filter_defines.svh
// Assertion macros shared by the peak clip filter RTL.
// No dependencies; included by the files that carry concurrent checks.
`ifndef ISOLATED_PEAK_CLIP_FILTER_DEFINES_SVH
`define ISOLATED_PEAK_CLIP_FILTER_DEFINES_SVH

// Flag a condition that must never be true outside reset.
`define IPCF_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("ipcf check failed: forbidden condition");

// Require a consequence in the cycle after an antecedent.
`define IPCF_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ipcf check failed: missing next-cycle consequence");

`endif

### hw/rtl/ipcf_pkg.sv
// Package for the isolated peak clip filter: sizes, codes, payload structs.
// No dependencies; used by every module of the block but ipcf_ram.
package ipcf_pkg;

   localparam int PIXEL_BITS     = 16;
   localparam int MAX_COLS       = 1024;
   localparam int MAX_ROWS       = 1024;
   localparam int COL_BITS       = $clog2(MAX_COLS);
   localparam int DIM_BITS       = 11;
   localparam int REG_INDEX_BITS = 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      ACT_PIXEL = 1'b0,
      ACT_DRAIN = 1'b1
   } action_type;

   typedef enum logic [REG_INDEX_BITS-1:0] {
      REG_FRAME_ROWS = 1'b0,
      REG_FRAME_COLS = 1'b1
   } reg_index_type;

   // Line buffer port controls driven by the front end.
   typedef struct packed {
      logic                  wr_en0;
      logic                  wr_en1;
      logic [COL_BITS-1:0]   wr_addr;
      logic [PIXEL_BITS-1:0] wr_data;
      logic [COL_BITS-1:0]   rd_addr_a;
      logic [COL_BITS-1:0]   rd_addr_b;
   } lb_ctrl_type;

   // Classification of an emitting transaction, waiting for line buffer data.
   typedef struct packed {
      logic                  cbank;
      logic                  has_left;
      logic                  has_right;
      logic                  has_up;
      logic                  has_down;
      logic [PIXEL_BITS-1:0] down;
      logic                  row_end;
      logic                  frame_end;
   } tag_type;

   // One queued filter job.
   typedef struct packed {
      logic [PIXEL_BITS-1:0] centre;
      logic [PIXEL_BITS-1:0] right;
      logic [PIXEL_BITS-1:0] up;
      logic [PIXEL_BITS-1:0] down;
      logic                  has_left;
      logic                  has_right;
      logic                  has_up;
      logic                  has_down;
      logic                  row_end;
      logic                  frame_end;
   } entry_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v,
                                                     input logic [DIM_BITS-1:0] hi);
      logic [DIM_BITS-1:0] r;
      if (v == '0) begin
         r = DIM_BITS'(1);
      end else if (v > hi) begin
         r = hi;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

### hw/rtl/ipcf_ram.sv
// Generic single-write, dual-read RAM with registered, read-first outputs.
// No dependencies.
module ipcf_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a <= mem_ff[rd_addr_a];
      rd_data_b <= mem_ff[rd_addr_b];
   end

endmodule

### hw/rtl/ipcf_front.sv
// Front end: frame registers, raster counters, transaction classification,
// line buffer addressing and queue credit. Depends on ipcf_pkg and the defines.
`include "isolated_peak_clip_filter_defines.svh"

module ipcf_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ipcf_pkg::REG_INDEX_BITS-1:0] csr_index,
   input  logic [ipcf_pkg::DIM_BITS-1:0]       csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [ipcf_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   output ipcf_pkg::lb_ctrl_type               lb_ctrl,
   input  logic [ipcf_pkg::PIXEL_BITS-1:0]     bank0_a,
   input  logic [ipcf_pkg::PIXEL_BITS-1:0]     bank0_b,
   input  logic [ipcf_pkg::PIXEL_BITS-1:0]     bank1_a,
   input  logic [ipcf_pkg::PIXEL_BITS-1:0]     bank1_b,
   output logic                                q_push,
   output ipcf_pkg::entry_type                 q_entry,
   input  logic                                q_pop
);

   logic [ipcf_pkg::DIM_BITS-1:0]  rows_ff, rows_in, cols_ff, cols_in;
   logic [ipcf_pkg::DIM_BITS-1:0]  in_row_ff, in_row_in;
   logic [ipcf_pkg::COL_BITS-1:0]  in_col_ff, in_col_in;
   logic                           busy_ff, busy_in;
   logic [ipcf_pkg::QCNT_BITS-1:0] pend_ff, pend_in;
   logic                           tag_valid_ff, tag_valid_in;
   ipcf_pkg::tag_type              tag_ff, tag_in;

   logic                          accept, is_drain, all_in;
   logic                          pix_acc, drn_acc, emit;
   logic [ipcf_pkg::DIM_BITS-1:0] col_next, rows_m1;
   logic                          row_end;

   assign req_ready = pend_ff < ipcf_pkg::QCNT_BITS'(ipcf_pkg::QUEUE_DEPTH);
   assign accept    = req_valid && req_ready;
   assign is_drain  = req_action == ipcf_pkg::ACT_DRAIN;
   assign all_in    = in_row_ff >= rows_ff;
   assign pix_acc   = accept && !is_drain && !all_in;
   assign drn_acc   = accept && is_drain && busy_ff && all_in;
   assign emit      = (pix_acc && in_row_ff != '0) || drn_acc;
   assign col_next  = {1'b0, in_col_ff} + ipcf_pkg::DIM_BITS'(1);
   assign rows_m1   = rows_ff - ipcf_pkg::DIM_BITS'(1);
   assign row_end   = col_next >= cols_ff;

   // Configuration: ignore writes while a frame is in progress.
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_wr_en && !busy_ff) begin
         case (csr_index)
            ipcf_pkg::REG_FRAME_ROWS: begin
               rows_in = ipcf_pkg::clamp_dim(csr_wr_data,
                                             ipcf_pkg::DIM_BITS'(ipcf_pkg::MAX_ROWS));
            end
            ipcf_pkg::REG_FRAME_COLS: begin
               cols_in = ipcf_pkg::clamp_dim(csr_wr_data,
                                             ipcf_pkg::DIM_BITS'(ipcf_pkg::MAX_COLS));
            end
            default: begin
            end
         endcase
      end
   end

   // Raster position; during drain the column counter walks the last row.
   always_comb begin
      in_row_in = in_row_ff;
      in_col_in = in_col_ff;
      busy_in   = busy_ff;
      if (pix_acc) begin
         busy_in = 1'b1;
         if (row_end) begin
            in_col_in = '0;
            in_row_in = in_row_ff + ipcf_pkg::DIM_BITS'(1);
         end else begin
            in_col_in = col_next[ipcf_pkg::COL_BITS-1:0];
         end
      end else if (drn_acc) begin
         if (row_end) begin
            in_row_in = '0;
            in_col_in = '0;
            busy_in   = 1'b0;
         end else begin
            in_col_in = col_next[ipcf_pkg::COL_BITS-1:0];
         end
      end
   end

   // Row k of the frame lives in bank k[0]; the other bank holds the row above.
   always_comb begin
      lb_ctrl.wr_en0    = pix_acc && !in_row_ff[0];
      lb_ctrl.wr_en1    = pix_acc && in_row_ff[0];
      lb_ctrl.wr_addr   = in_col_ff;
      lb_ctrl.wr_data   = req_pixel_in;
      lb_ctrl.rd_addr_a = in_col_ff;
      lb_ctrl.rd_addr_b = col_next[ipcf_pkg::COL_BITS-1:0];
   end

   always_comb begin
      tag_valid_in     = emit;
      tag_in.cbank     = is_drain ? rows_m1[0] : ~in_row_ff[0];
      tag_in.has_left  = in_col_ff != '0;
      tag_in.has_right = !row_end;
      tag_in.has_up    = is_drain ? (rows_ff > ipcf_pkg::DIM_BITS'(1))
                                  : (in_row_ff >= ipcf_pkg::DIM_BITS'(2));
      tag_in.has_down  = !is_drain;
      tag_in.down      = is_drain ? '0 : req_pixel_in;
      tag_in.row_end   = row_end;
      tag_in.frame_end = row_end && is_drain;
   end

   // Credit counts jobs reserved in the tag stage and the queue.
   always_comb begin
      pend_in = pend_ff + ipcf_pkg::QCNT_BITS'(emit) - ipcf_pkg::QCNT_BITS'(q_pop);
   end

   // Join the tag with line buffer data in the cycle after the read.
   always_comb begin
      q_push             = tag_valid_ff;
      q_entry.centre     = tag_ff.cbank ? bank1_a : bank0_a;
      q_entry.right      = tag_ff.cbank ? bank1_b : bank0_b;
      q_entry.up         = tag_ff.cbank ? bank0_a : bank1_a;
      q_entry.down       = tag_ff.down;
      q_entry.has_left   = tag_ff.has_left;
      q_entry.has_right  = tag_ff.has_right;
      q_entry.has_up     = tag_ff.has_up;
      q_entry.has_down   = tag_ff.has_down;
      q_entry.row_end    = tag_ff.row_end;
      q_entry.frame_end  = tag_ff.frame_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff      <= ipcf_pkg::DIM_BITS'(1);
         cols_ff      <= ipcf_pkg::DIM_BITS'(1);
         in_row_ff    <= '0;
         in_col_ff    <= '0;
         busy_ff      <= 1'b0;
         pend_ff      <= '0;
         tag_valid_ff <= 1'b0;
      end else begin
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         in_row_ff    <= in_row_in;
         in_col_ff    <= in_col_in;
         busy_ff      <= busy_in;
         pend_ff      <= pend_in;
         tag_valid_ff <= tag_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tag_ff <= tag_in;
   end

   `IPCF_ASSERT_NEVER(a_credit_bound, clock, reset,
                      pend_ff > ipcf_pkg::QCNT_BITS'(ipcf_pkg::QUEUE_DEPTH))
   `IPCF_ASSERT_NEXT(a_frame_end_idles, clock, reset,
                     drn_acc && row_end, !busy_ff && in_row_ff == '0 && in_col_ff == '0)

endmodule

### hw/rtl/ipcf_queue.sv
// Short job queue between the front end and the filter back end.
// Depends on ipcf_pkg and the defines.
`include "isolated_peak_clip_filter_defines.svh"

module ipcf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ipcf_pkg::entry_type push_entry,
   input  logic                pop,
   output ipcf_pkg::entry_type head,
   output logic                empty
);

   ipcf_pkg::entry_type            q_ff [ipcf_pkg::QUEUE_DEPTH];
   logic [ipcf_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [ipcf_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                           full;

   assign empty = count_ff == '0;
   assign full  = count_ff == ipcf_pkg::QCNT_BITS'(ipcf_pkg::QUEUE_DEPTH);
   assign head  = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + ipcf_pkg::QPTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + ipcf_pkg::QPTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff + ipcf_pkg::QCNT_BITS'(push) - ipcf_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `IPCF_ASSERT_NEVER(a_no_overflow, clock, reset, push && full && !pop)
   `IPCF_ASSERT_NEVER(a_no_underflow, clock, reset, pop && empty)

endmodule

### hw/rtl/ipcf_back.sv
// Back end: four-neighbour peak clip on queued jobs and the result register.
// Depends on ipcf_pkg.
module ipcf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  ipcf_pkg::entry_type             head,
   input  logic                            empty,
   output logic                            pop,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ipcf_pkg::PIXEL_BITS-1:0] rsp_pixel_out,
   output logic                            rsp_row_end,
   output logic                            rsp_frame_end
);

   logic                            valid_ff, valid_in;
   logic [ipcf_pkg::PIXEL_BITS-1:0] pixel_ff, pixel_in;
   logic                            row_end_ff, frame_end_ff;
   logic [ipcf_pkg::PIXEL_BITS-1:0] left_ff;

   logic [ipcf_pkg::PIXEL_BITS-1:0] nb [4];
   logic                            ok [4];
   logic [ipcf_pkg::PIXEL_BITS-1:0] mx;
   logic                            peak;

   assign pop = !empty && (!valid_ff || rsp_ready);

   // Left neighbour is the centre of the previous job in the same row.
   always_comb begin
      nb[0] = head.right;
      nb[1] = left_ff;
      nb[2] = head.up;
      nb[3] = head.down;
      ok[0] = head.has_right;
      ok[1] = head.has_left;
      ok[2] = head.has_up;
      ok[3] = head.has_down;
      mx    = '0;
      peak  = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (ok[k]) begin
            if (nb[k] > mx) begin
               mx = nb[k];
            end
            if (head.centre <= nb[k]) begin
               peak = 1'b0;
            end
         end
      end
      pixel_in = peak ? mx : head.centre;
   end

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         pixel_ff     <= pixel_in;
         row_end_ff   <= head.row_end;
         frame_end_ff <= head.frame_end;
         left_ff      <= head.centre;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_pixel_out = pixel_ff;
   assign rsp_row_end   = row_end_ff;
   assign rsp_frame_end = frame_end_ff;

endmodule

### hw/rtl/isolated_peak_clip_filter.sv
// Top level of the isolated peak clip filter: front end, line buffers,
// job queue and back end. Depends on ipcf_pkg, ipcf_ram, ipcf_front,
// ipcf_queue and ipcf_back.
//
//   channel | ports                                     | transfer
//   --------+-------------------------------------------+--------------------------
//   req     | req_valid/ready, req_action, req_pixel_in | valid && ready
//   rsp     | rsp_valid/ready, rsp_pixel_out, _row_end, | valid && ready
//           | rsp_frame_end                             |
//   csr     | csr_wr_en, csr_index, csr_wr_data         | csr_wr_en (no wait)
//
// One transaction per clock sustained while the rsp side keeps up. A result reaches
// the rsp register after the transaction that causes it passes the line buffer
// read and tag register, the job queue and the neighbour compare in the back end.
// Reset is synchronous; it clears counters, queue and handshakes. Line buffers
// are not cleared and need no clearing pass: every entry is written before its
// value is used within a frame.
// Up to four jobs may be outstanding (tag stage plus queue); req_ready drops
// when that credit is used, so a stalled rsp side backs up into req.
module isolated_peak_clip_filter (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ipcf_pkg::REG_INDEX_BITS-1:0] csr_index,
   input  logic [ipcf_pkg::DIM_BITS-1:0]       csr_wr_data,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic [ipcf_pkg::PIXEL_BITS-1:0]     req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ipcf_pkg::PIXEL_BITS-1:0]     rsp_pixel_out,
   output logic                                rsp_row_end,
   output logic                                rsp_frame_end
);

   ipcf_pkg::lb_ctrl_type           lb_ctrl;
   logic [ipcf_pkg::PIXEL_BITS-1:0] bank0_a, bank0_b, bank1_a, bank1_b;
   logic                            q_push, q_pop, q_empty;
   ipcf_pkg::entry_type             q_entry, q_head;

   // Classify transactions, track raster position, drive line buffers.
   ipcf_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (csr_index),
      .csr_wr_data  (csr_wr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_action   (req_action),
      .req_pixel_in (req_pixel_in),
      .lb_ctrl      (lb_ctrl),
      .bank0_a      (bank0_a),
      .bank0_b      (bank0_b),
      .bank1_a      (bank1_a),
      .bank1_b      (bank1_b),
      .q_push       (q_push),
      .q_entry      (q_entry),
      .q_pop        (q_pop)
   );

   // Two line buffers alternate by row parity; each reads column c and c+1.
   ipcf_ram #(
      .WIDTH (ipcf_pkg::PIXEL_BITS),
      .DEPTH (ipcf_pkg::MAX_COLS)
   ) u_bank0 (
      .clock     (clock),
      .wr_en     (lb_ctrl.wr_en0),
      .wr_addr   (lb_ctrl.wr_addr),
      .wr_data   (lb_ctrl.wr_data),
      .rd_addr_a (lb_ctrl.rd_addr_a),
      .rd_data_a (bank0_a),
      .rd_addr_b (lb_ctrl.rd_addr_b),
      .rd_data_b (bank0_b)
   );

   ipcf_ram #(
      .WIDTH (ipcf_pkg::PIXEL_BITS),
      .DEPTH (ipcf_pkg::MAX_COLS)
   ) u_bank1 (
      .clock     (clock),
      .wr_en     (lb_ctrl.wr_en1),
      .wr_addr   (lb_ctrl.wr_addr),
      .wr_data   (lb_ctrl.wr_data),
      .rd_addr_a (lb_ctrl.rd_addr_a),
      .rd_data_a (bank1_a),
      .rd_addr_b (lb_ctrl.rd_addr_b),
      .rd_data_b (bank1_b)
   );

   // Decouple front and back so either side can stall.
   ipcf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .empty      (q_empty)
   );

   // Clip isolated peaks and hold the result until it is taken.
   ipcf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head          (q_head),
      .empty         (q_empty),
      .pop           (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_row_end   (rsp_row_end),
      .rsp_frame_end (rsp_frame_end)
   );

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for isolated_peak_clip_filter: directed peak cases,
// long rows and columns, and random frames. Depends on ipcf_pkg and the filter RTL.
module testbench;

   // Cycles with no accepted transaction on either channel before giving up.
   localparam int STALL_LIMIT   = 2000;
   // Cycles to let the pipeline settle before a register write or the verdict.
   localparam int SETTLE_CYCLES = 16;

   typedef enum {
      FILL_ANY,
      FILL_TIES,
      FILL_EXTREMES,
      FILL_PEAKS
   } fill_type;

   typedef struct {
      logic [ipcf_pkg::PIXEL_BITS-1:0] pixel;
      logic                            row_end;
      logic                            frame_end;
   } filtered_pixel_type;

   logic                                clock         = 1'b0;
   logic                                reset         = 1'b1;
   logic                                csr_wr_en     = 1'b0;
   logic [ipcf_pkg::REG_INDEX_BITS-1:0] csr_index     = ipcf_pkg::REG_FRAME_ROWS;
   logic [ipcf_pkg::DIM_BITS-1:0]       csr_wr_data   = '0;
   logic                                req_valid     = 1'b0;
   logic                                req_ready;
   logic                                req_action    = ipcf_pkg::ACT_PIXEL;
   logic [ipcf_pkg::PIXEL_BITS-1:0]     req_pixel_in  = '0;
   logic                                rsp_valid;
   logic                                rsp_ready     = 1'b0;
   logic [ipcf_pkg::PIXEL_BITS-1:0]     rsp_pixel_out;
   logic                                rsp_row_end;
   logic                                rsp_frame_end;

   int          send_idle_pct;
   int          recv_idle_pct;
   int          error_count;
   int          stall_cycles;
   int unsigned counted_items;

   // Filter shadow: two line buffers, raster positions and the frame size.
   logic [ipcf_pkg::PIXEL_BITS-1:0] upper_line  [ipcf_pkg::MAX_COLS];
   logic [ipcf_pkg::PIXEL_BITS-1:0] middle_line [ipcf_pkg::MAX_COLS];
   int unsigned                     in_row, in_col, out_row, out_col;
   bit                              frame_active;
   int unsigned                     rows_cfg = 1;
   int unsigned                     cols_cfg = 1;
   filtered_pixel_type              filtered_q [$];

   isolated_peak_clip_filter dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Filter the pixel at the output position, queue its result and shift the
   // column's buffers. Return the frame_end flag of the result.
   function automatic bit emit_filtered(bit has_down,
                                        logic [ipcf_pkg::PIXEL_BITS-1:0] down);
      int unsigned                     c;
      logic [ipcf_pkg::PIXEL_BITS-1:0] centre;
      logic [ipcf_pkg::PIXEL_BITS-1:0] largest;
      logic [ipcf_pkg::PIXEL_BITS-1:0] nb [4];
      bit                              present [4];
      bit                              peak;
      filtered_pixel_type              r;
      c          = out_col;
      centre     = middle_line[c];
      present[0] = (out_col + 1 < cols_cfg);
      nb[0]      = present[0] ? middle_line[c + 1] : '0;
      present[1] = (out_col > 0);
      nb[1]      = present[1] ? upper_line[c - 1] : '0;
      present[2] = (out_row > 0);
      nb[2]      = present[2] ? upper_line[c] : '0;
      present[3] = has_down;
      nb[3]      = down;
      largest    = '0;
      peak       = 1'b1;
      for (int k = 0; k < 4; k++) begin
         if (present[k]) begin
            if (nb[k] > largest) largest = nb[k];
            if (centre <= nb[k]) peak = 1'b0;
         end
      end
      // A strict peak is clipped to its largest neighbour; no neighbours gives 0.
      r.pixel     = peak ? largest : centre;
      r.row_end   = (out_col + 1 >= cols_cfg);
      r.frame_end = r.row_end && (out_row + 1 >= rows_cfg);
      filtered_q  = {filtered_q, r};
      upper_line[c]  = centre;
      middle_line[c] = down;
      out_col++;
      if (out_col >= cols_cfg) begin
         out_col = 0;
         out_row++;
      end
      return r.frame_end;
   endfunction

   function automatic void predict_transaction(ipcf_pkg::action_type act,
                                               logic [ipcf_pkg::PIXEL_BITS-1:0] pix);
      bit all_in;
      all_in = (in_row >= rows_cfg);
      if (act == ipcf_pkg::ACT_PIXEL) begin
         // Drop pixels once the whole frame is in and still draining.
         if (all_in) return;
         frame_active = 1'b1;
         if (in_row == 0) middle_line[in_col] = pix;
         else void'(emit_filtered(1'b1, pix));
         in_col++;
         if (in_col >= cols_cfg) begin
            in_col = 0;
            in_row++;
         end
      end else if (frame_active && all_in) begin
         // Drain ticks flush the last row; the final one closes the frame.
         if (emit_filtered(1'b0, '0)) begin
            in_row       = 0;
            in_col       = 0;
            out_row      = 0;
            out_col      = 0;
            frame_active = 1'b0;
         end
      end
   endfunction

   function automatic void predict_csr_write(ipcf_pkg::reg_index_type idx,
                                             logic [ipcf_pkg::DIM_BITS-1:0] value);
      int unsigned dim;
      if (frame_active) return;
      dim = (value == 0) ? 1 : value;
      if (idx == ipcf_pkg::REG_FRAME_ROWS)
         rows_cfg = (dim > ipcf_pkg::MAX_ROWS) ? ipcf_pkg::MAX_ROWS : dim;
      else
         cols_cfg = (dim > ipcf_pkg::MAX_COLS) ? ipcf_pkg::MAX_COLS : dim;
   endfunction

   function automatic logic [ipcf_pkg::PIXEL_BITS-1:0] pick_pixel(fill_type fill);
      case (fill)
         FILL_ANY:      return ipcf_pkg::PIXEL_BITS'($urandom);
         FILL_TIES:     return ipcf_pkg::PIXEL_BITS'($urandom_range(3));
         FILL_EXTREMES: return $urandom_range(1) ? {ipcf_pkg::PIXEL_BITS{1'b1}}
                                                 : {ipcf_pkg::PIXEL_BITS{1'b0}};
         default:       return ($urandom_range(4) == 0)
                                  ? ipcf_pkg::PIXEL_BITS'($urandom)
                                  : ipcf_pkg::PIXEL_BITS'($urandom_range(15));
      endcase
   endfunction

   // Mostly small sizes, now and then a zero (taken as one) or a wider one.
   function automatic logic [ipcf_pkg::DIM_BITS-1:0] pick_dim(int unsigned hi);
      int unsigned roll;
      roll = $urandom_range(19);
      if (roll == 0) return '0;
      if (roll == 1) return ipcf_pkg::DIM_BITS'($urandom_range(hi, 3 * hi));
      return ipcf_pkg::DIM_BITS'($urandom_range(1, hi));
   endfunction

   task automatic report_mismatch(string what, logic [ipcf_pkg::PIXEL_BITS-1:0] got,
                                  logic [ipcf_pkg::PIXEL_BITS-1:0] want);
      error_count++;
      $display("%0t ns: mismatch on %s: got %h, want %h", $time, what, got, want);
   endtask

   // Called and returning at a falling edge. Hold the transaction until accepted.
   task automatic send_transaction(ipcf_pkg::action_type act,
                                   logic [ipcf_pkg::PIXEL_BITS-1:0] pix);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_action   <= act;
      req_pixel_in <= pix;
      do @(posedge clock); while (!req_ready);
      predict_transaction(act, pix);
      @(negedge clock);
   endtask

   // Hold off the sender until every expected result is out, then let the
   // pipeline settle so that no pixel is still in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (filtered_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic configure_frame(logic [ipcf_pkg::DIM_BITS-1:0] rows,
                                  logic [ipcf_pkg::DIM_BITS-1:0] cols);
      csr_wr_en   <= 1'b1;
      csr_index   <= ipcf_pkg::REG_FRAME_ROWS;
      csr_wr_data <= rows;
      @(posedge clock);
      predict_csr_write(ipcf_pkg::REG_FRAME_ROWS, rows);
      @(negedge clock);
      csr_index   <= ipcf_pkg::REG_FRAME_COLS;
      csr_wr_data <= cols;
      @(posedge clock);
      predict_csr_write(ipcf_pkg::REG_FRAME_COLS, cols);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One whole frame plus its drain ticks, with an occasional early drain and
   // an occasional stray pixel while draining; the block ignores both.
   task automatic send_frame(fill_type fill);
      int unsigned pixels;
      pixels = rows_cfg * cols_cfg;
      for (int unsigned i = 0; i < pixels; i++) begin
         if ($urandom_range(24) == 0)
            send_transaction(ipcf_pkg::ACT_DRAIN, ipcf_pkg::PIXEL_BITS'($urandom));
         send_transaction(ipcf_pkg::ACT_PIXEL, pick_pixel(fill));
      end
      for (int unsigned j = 0; j < cols_cfg; j++) begin
         if ($urandom_range(9) == 0)
            send_transaction(ipcf_pkg::ACT_PIXEL, ipcf_pkg::PIXEL_BITS'($urandom));
         send_transaction(ipcf_pkg::ACT_DRAIN, ipcf_pkg::PIXEL_BITS'($urandom));
      end
      counted_items += pixels + cols_cfg;
   endtask

   // Lone pixel frames, with zero written to both sizes (taken as one).
   task automatic test_single_pixel();
      wait_idle();
      configure_frame('0, '0);
      send_transaction(ipcf_pkg::ACT_DRAIN, 16'h1234);   // no frame in progress
      send_transaction(ipcf_pkg::ACT_PIXEL, 16'hFFFF);
      send_transaction(ipcf_pkg::ACT_PIXEL, 16'h0001);   // frame already complete
      send_transaction(ipcf_pkg::ACT_DRAIN, 16'h0000);   // no neighbours: result is 0
      send_transaction(ipcf_pkg::ACT_PIXEL, 16'h0000);
      send_transaction(ipcf_pkg::ACT_DRAIN, 16'hFFFF);
   endtask

   // Hand-built 3x3 frame: top-edge peak, blocked centre, ties, bottom-row
   // peaks; then a single column where only vertical neighbours count.
   task automatic test_directed_peaks();
      logic [ipcf_pkg::PIXEL_BITS-1:0] grid [9];
      logic [ipcf_pkg::PIXEL_BITS-1:0] column [3];
      grid   = '{16'h0000, 16'hFFFF, 16'h0005,
                 16'h0003, 16'h0009, 16'h0005,
                 16'h0008, 16'h0002, 16'h0006};
      column = '{16'h0005, 16'h0009, 16'h0002};
      wait_idle();
      configure_frame(11'd3, 11'd3);
      foreach (grid[i]) begin
         if (i == 6) send_transaction(ipcf_pkg::ACT_DRAIN, '0);   // too early, ignored
         send_transaction(ipcf_pkg::ACT_PIXEL, grid[i]);
      end
      send_transaction(ipcf_pkg::ACT_DRAIN, '0);
      send_transaction(ipcf_pkg::ACT_PIXEL, 16'hFFFF);           // dropped while draining
      send_transaction(ipcf_pkg::ACT_DRAIN, '0);
      send_transaction(ipcf_pkg::ACT_DRAIN, '0);
      wait_idle();
      configure_frame(11'd3, 11'd1);
      foreach (column[i]) send_transaction(ipcf_pkg::ACT_PIXEL, column[i]);
      send_transaction(ipcf_pkg::ACT_DRAIN, '0);
   endtask

   // Long rows and a long single column, mostly beyond the random sizes.
   task automatic test_long_frames();
      wait_idle();
      configure_frame(11'd2, 11'd40);
      send_frame(FILL_ANY);
      wait_idle();
      configure_frame(11'd1, 11'd16);
      send_frame(FILL_EXTREMES);
      wait_idle();
      configure_frame(11'd24, 11'd1);
      send_frame(FILL_PEAKS);
   endtask

   // Random sizes, each used for one to three back-to-back frames.
   task automatic test_random_frames(int unsigned target);
      int unsigned start;
      start = counted_items;
      while (counted_items - start < target) begin
         wait_idle();
         configure_frame(pick_dim(5), pick_dim(8));
         repeat ($urandom_range(1, 3)) send_frame(fill_type'($urandom_range(3)));
      end
   endtask

   // Randomly stall the result side.
   always @(negedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // Compare each accepted result with the oldest expectation.
   always @(posedge clock) begin
      filtered_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (filtered_q.size() == 0) begin
            report_mismatch("unexpected result", rsp_pixel_out, '0);
         end else begin
            want = filtered_q.pop_front();
            if (rsp_pixel_out !== want.pixel)
               report_mismatch("pixel_out", rsp_pixel_out, want.pixel);
            if (rsp_row_end !== want.row_end)
               report_mismatch("row_end", ipcf_pkg::PIXEL_BITS'(rsp_row_end),
                               ipcf_pkg::PIXEL_BITS'(want.row_end));
            if (rsp_frame_end !== want.frame_end)
               report_mismatch("frame_end", ipcf_pkg::PIXEL_BITS'(rsp_frame_end),
                               ipcf_pkg::PIXEL_BITS'(want.frame_end));
         end
      end
   end

   // Watchdog: end the run when no transaction moves for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin
      send_idle_pct = 22;
      recv_idle_pct = 50;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_single_pixel();
      test_directed_peaks();
      test_long_frames();
      test_random_frames(50);
      // Swap the idle ratios, then run with no idling at all.
      send_idle_pct = 50;
      recv_idle_pct = 22;
      test_random_frames(50);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_frames(50);
      wait_idle();
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
